// ===== hdl/slcd_pkg.sv =====
// ----------------------------------------------------------------------------
// slcd_pkg - shared types and constants of the sync/length/CRC-32 deframer
// Phase codes, result kinds, register indexes, CRC constants and the
// result record passed to the output register.
// ----------------------------------------------------------------------------
package slcd_pkg;

	// Receiver phase, one-hot
	typedef enum logic [5:0] {
		PH_SYNC0   = 6'b000001,
		PH_SYNC1   = 6'b000010,
		PH_LEN_LO  = 6'b000100,
		PH_LEN_HI  = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CRC     = 6'b100000
	} slcd_phase_t;

	// Result kinds
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_CRC_ERR = 2'd2;
	localparam logic [1:0] KIND_LEN_ERR = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

	// Register reset values
	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4088;

	// Reflected CRC-32
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	// Trailer length in bytes
	localparam logic [15:0] CRC_BYTES = 16'd4;

	// One result item
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  payload_byte;
		logic [15:0] payload_length;
	} slcd_result_t;

endpackage

// ===== hdl/slcd_if.sv =====
// ----------------------------------------------------------------------------
// slcd_if - valid/ready channels of the deframer
// Received byte channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------

// Received byte stream
interface slcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Result stream
interface slcd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [15:0] payload_length;

	modport source (output valid, output result_kind, output payload_byte,
		output payload_length, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input payload_length, output ready);
endinterface

// ===== hdl/slcd_crc_byte.sv =====
// ----------------------------------------------------------------------------
// slcd_crc_byte - bytewise reflected CRC-32 update
// Folds one byte into the CRC register, eight XOR/shift steps unrolled.
// ----------------------------------------------------------------------------
module slcd_crc_byte
	import slcd_pkg::*;
(
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	// Shift out eight bits, LSB first
	always_comb begin
		crc_out = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			crc_out = crc_out[0] ? (CRC_POLY ^ (crc_out >> 1)) : (crc_out >> 1);
		end
	end

endmodule

// ===== hdl/slcd_out_reg.sv =====
// ----------------------------------------------------------------------------
// slcd_out_reg - result register
// Holds one result transaction until the sink takes it; reports when a new
// result can be loaded in the same cycle.
// ----------------------------------------------------------------------------
module slcd_out_reg
	import slcd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  slcd_result_t data,
	output logic         free,
	slcd_out_if.source   res
);

	logic         valid_q;
	slcd_result_t data_q;

	// Free when empty or being drained this cycle
	assign free = !valid_q || res.ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign res.valid          = valid_q;
	assign res.result_kind    = data_q.result_kind;
	assign res.payload_byte   = data_q.payload_byte;
	assign res.payload_length = data_q.payload_length;

endmodule

// ===== hdl/sync_length_crc32_deframer_core.sv =====
// A result appears in the result register in the cycle after its byte is accepted.
// One byte per cycle, save when stalled; CRC update and phase logic are combinational.
// A byte is taken whenever the result register is empty or being read in that cycle.
// Reset (arst_n low): hunt for first sync, CRC all ones, result register empty,
// sync_first 0xAA, sync_second 0x55, max_payload 4088.
// ----------------------------------------------------------------------------
// sync_length_crc32_deframer_core - length-prefixed frame receiver with CRC-32
// Hunts two sync bytes, reads a little-endian length, passes payload bytes
// through, checks a little-endian CRC-32 trailer and reports frame status.
// ----------------------------------------------------------------------------
module sync_length_crc32_deframer_core
	import slcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	slcd_in_if.sink     rx,
	slcd_out_if.source  res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers
	logic [7:0]  sync_first_q;
	logic [7:0]  sync_second_q;
	logic [15:0] max_payload_q;

	// Frame state
	slcd_phase_t phase_q, phase_d;
	logic [15:0] frame_length_q, frame_length_d;
	logic [15:0] byte_count_q, byte_count_d;
	logic [31:0] running_crc_q, running_crc_d;
	logic [31:0] received_crc_q, received_crc_d;

	logic         acc;
	logic         out_free;
	logic         res_load;
	slcd_result_t res_data;
	logic [31:0]  crc_next;
	logic [15:0]  count_inc;
	logic [7:0]   b;

	assign b         = rx.rx_byte;
	assign rx.ready  = out_free;
	assign acc       = rx.valid && rx.ready;
	assign count_inc = byte_count_q + 16'd1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_data[7:0];
				CFG_SYNC_SECOND: sync_second_q <= cfg_data[7:0];
				CFG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				default: ;
			endcase
		end
	end

	slcd_crc_byte u_crc (
		.crc_in  (running_crc_q),
		.data    (b),
		.crc_out (crc_next)
	);

	// Phase logic and result selection
	always_comb begin
		phase_d        = phase_q;
		frame_length_d = frame_length_q;
		byte_count_d   = byte_count_q;
		running_crc_d  = running_crc_q;
		received_crc_d = received_crc_q;
		res_load       = 1'b0;
		res_data       = '0;
		case (phase_q)
			PH_SYNC1: begin
				if (b == sync_second_q) begin
					phase_d = PH_LEN_LO;
				end else if (b != sync_first_q) begin
					phase_d = PH_SYNC0;
				end
			end
			PH_LEN_LO: begin
				frame_length_d = {8'd0, b};
				phase_d        = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				frame_length_d = {b, frame_length_q[7:0]};
				if (frame_length_d > max_payload_q) begin
					phase_d                 = PH_SYNC0;
					res_load                = 1'b1;
					res_data.result_kind    = KIND_LEN_ERR;
					res_data.payload_length = frame_length_d;
				end else begin
					running_crc_d = CRC_ONES;
					byte_count_d  = '0;
					if (frame_length_d == '0) begin
						received_crc_d = '0;
						phase_d        = PH_CRC;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				running_crc_d = crc_next;
				byte_count_d  = count_inc;
				// last payload byte: start collecting the trailer
				if (count_inc >= frame_length_q) begin
					byte_count_d   = '0;
					received_crc_d = '0;
					phase_d        = PH_CRC;
				end
				res_load              = 1'b1;
				res_data.result_kind  = KIND_DATA;
				res_data.payload_byte = b;
			end
			PH_CRC: begin
				received_crc_d = {b, received_crc_q[31:8]};
				byte_count_d   = count_inc;
				if (count_inc >= CRC_BYTES) begin
					phase_d                 = PH_SYNC0;
					res_load                = 1'b1;
					res_data.payload_length = frame_length_q;
					res_data.result_kind    = (received_crc_d == ~running_crc_q) ?
						KIND_GOOD : KIND_CRC_ERR;
				end
			end
			default: begin
				phase_d = (b == sync_first_q) ? PH_SYNC1 : PH_SYNC0;
			end
		endcase
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SYNC0;
			frame_length_q <= '0;
			byte_count_q   <= '0;
			running_crc_q  <= CRC_ONES;
			received_crc_q <= '0;
		end else if (acc) begin
			phase_q        <= phase_d;
			frame_length_q <= frame_length_d;
			byte_count_q   <= byte_count_d;
			running_crc_q  <= running_crc_d;
			received_crc_q <= received_crc_d;
		end
	end

	slcd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (acc && res_load),
		.data   (res_data),
		.free   (out_free),
		.res    (res)
	);

	// Checks
	a_payload_passes: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_PAYLOAD |=> res.valid && res.result_kind == KIND_DATA
		&& res.payload_byte == $past(b))
		else $error("payload byte not passed to result register");

	a_len_err: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_LEN_HI && {b, frame_length_q[7:0]} > max_payload_q
		|=> res.valid && res.result_kind == KIND_LEN_ERR && phase_q == PH_SYNC0)
		else $error("oversize length not reported");

	a_trailer_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CRC |-> byte_count_q < CRC_BYTES)
		else $error("trailer byte count out of range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> rx.ready)
		else $error("input stalled with empty result register");

endmodule
